// ===== rtl/core/four_wheel_velocity_mixer_unit_assert.svh =====
// Assertion macros shared by the velocity mixer checker.
// Depends on nothing; included by the checker file.
`ifndef FOUR_WHEEL_VELOCITY_MIXER_UNIT_ASSERT_SVH
`define FOUR_WHEEL_VELOCITY_MIXER_UNIT_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define FWVM_ASSERT_SAME(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("velocity mixer check failed");

// Checks that a condition implies another in the next cycle.
`define FWVM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("velocity mixer check failed");

`endif

// ===== rtl/core/fwvm_pkg.sv =====
// Package of the four wheel velocity mixer: widths, register codes and resets.
// Used by the configuration registers and the top level.
`timescale 1ns / 1ps

package fwvm_pkg;

  localparam int unsigned NumWheels = 4;

  typedef enum logic [2:0] {
    REG_COEF_FORWARD     = 3'd0,
    REG_COEF_STRAFE      = 3'd1,
    REG_COEF_TURN        = 3'd2,
    REG_OUTPUT_SCALE     = 3'd3,
    REG_FORWARD_DEADBAND = 3'd4,
    REG_STRAFE_DEADBAND  = 3'd5,
    REG_TURN_DEADBAND    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] coef_forward;
    logic [15:0] coef_strafe;
    logic [15:0] coef_turn;
    logic [15:0] output_scale;
    logic [14:0] forward_deadband;
    logic [14:0] strafe_deadband;
    logic [14:0] turn_deadband;
  } cfg_t;

  localparam logic [15:0] COEF_FORWARD_RST     = 16'd26218;
  localparam logic [15:0] COEF_STRAFE_RST      = 16'd15905;
  localparam logic [15:0] COEF_TURN_RST        = 16'd6420;
  localparam logic [15:0] OUTPUT_SCALE_RST     = 16'd2511;
  localparam logic [14:0] FORWARD_DEADBAND_RST = 15'd41;
  localparam logic [14:0] STRAFE_DEADBAND_RST  = 15'd41;
  localparam logic [14:0] TURN_DEADBAND_RST    = 15'd64;

  // Per wheel sign masks: bit k set means wheel k subtracts that term.
  localparam logic [NumWheels-1:0] NEG_FORWARD = 4'b0101;
  localparam logic [NumWheels-1:0] NEG_STRAFE  = 4'b1100;

  localparam logic signed [8:0] WHEEL_MAX = 9'sd255;
  localparam logic signed [8:0] WHEEL_MIN = -9'sd255;
  localparam logic [36:0] TRUNC_BIAS = 37'd65535;

endpackage

// ===== rtl/core/fwvm_cfg_regs.sv =====
// Configuration register file of the velocity mixer.
// Depends on fwvm_pkg for the register codes, reset values and cfg_t.
`timescale 1ns / 1ps

module fwvm_cfg_regs import fwvm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        cfg_ready_o,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COEF_FORWARD:     cfg_d.coef_forward     = cfg_data_i;
        REG_COEF_STRAFE:      cfg_d.coef_strafe      = cfg_data_i;
        REG_COEF_TURN:        cfg_d.coef_turn        = cfg_data_i;
        REG_OUTPUT_SCALE:     cfg_d.output_scale     = cfg_data_i;
        REG_FORWARD_DEADBAND: cfg_d.forward_deadband = cfg_data_i[14:0];
        REG_STRAFE_DEADBAND:  cfg_d.strafe_deadband  = cfg_data_i[14:0];
        REG_TURN_DEADBAND:    cfg_d.turn_deadband    = cfg_data_i[14:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_forward     <= COEF_FORWARD_RST;
      cfg_q.coef_strafe      <= COEF_STRAFE_RST;
      cfg_q.coef_turn        <= COEF_TURN_RST;
      cfg_q.output_scale     <= OUTPUT_SCALE_RST;
      cfg_q.forward_deadband <= FORWARD_DEADBAND_RST;
      cfg_q.strafe_deadband  <= STRAFE_DEADBAND_RST;
      cfg_q.turn_deadband    <= TURN_DEADBAND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/four_wheel_velocity_mixer_unit.sv =====
// Throughput: one item per cycle through a four stage pipeline while the output
// is not held off by out_ready_i; the input products, the wheel sums, the output
// scaling and the clamp each own a stage.
// Reset clears every stage valid bit and loads the register reset values.
// Depends on fwvm_pkg and fwvm_cfg_regs.
`timescale 1ns / 1ps

module four_wheel_velocity_mixer_unit import fwvm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic signed [15:0] forward_vel_i,
  input  logic signed [15:0] strafe_vel_i,
  input  logic signed [15:0] turn_rate_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [8:0] wheel_front_a_o,
  output logic signed [8:0] wheel_front_b_o,
  output logic signed [8:0] wheel_rear_a_o,
  output logic signed [8:0] wheel_rear_b_o,
  output logic              stopped_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  cfg_t cfg;

  fwvm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready   = !s4_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
      if (s4_ready) s4_valid_q <= s3_valid_q;
    end
  end

  // Stage one: deadband test and the three input products.
  logic [16:0] mag_fwd, mag_str, mag_turn;
  logic        stop_d;
  logic signed [32:0] prod_fwd_d, prod_str_d, prod_turn_d;
  logic signed [32:0] prod_fwd_q, prod_str_q, prod_turn_q;
  logic        stop1_q;

  assign mag_fwd  = forward_vel_i[15] ? 17'(-$signed({forward_vel_i[15], forward_vel_i}))
                                      : {1'b0, forward_vel_i};
  assign mag_str  = strafe_vel_i[15] ? 17'(-$signed({strafe_vel_i[15], strafe_vel_i}))
                                     : {1'b0, strafe_vel_i};
  assign mag_turn = turn_rate_i[15] ? 17'(-$signed({turn_rate_i[15], turn_rate_i}))
                                    : {1'b0, turn_rate_i};
  assign stop_d = (mag_fwd < {2'b00, cfg.forward_deadband})
               && (mag_str < {2'b00, cfg.strafe_deadband})
               && (mag_turn < {2'b00, cfg.turn_deadband});

  assign prod_fwd_d  = 33'($signed({1'b0, cfg.coef_forward})) * 33'(forward_vel_i);
  assign prod_str_d  = 33'($signed({1'b0, cfg.coef_strafe})) * 33'(strafe_vel_i);
  assign prod_turn_d = 33'($signed({1'b0, cfg.coef_turn})) * 33'(turn_rate_i);

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      prod_fwd_q  <= prod_fwd_d;
      prod_str_q  <= prod_str_d;
      prod_turn_q <= prod_turn_d;
      stop1_q     <= stop_d;
    end
  end

  // Stage two: signed wheel mix with floor shifts.
  logic signed [33:0] fwd_ext, str_ext;
  logic signed [33:0] lin   [NumWheels];
  logic signed [19:0] spd_d [NumWheels];
  logic signed [19:0] spd_q [NumWheels];
  logic signed [16:0] rot;
  logic               stop2_q;

  assign fwd_ext = {prod_fwd_q[32], prod_fwd_q};
  assign str_ext = {prod_str_q[32], prod_str_q};
  assign rot     = prod_turn_q[32:16];

  always_comb begin
    for (int unsigned k = 0; k < NumWheels; k++) begin
      lin[k]   = (NEG_FORWARD[k] ? -fwd_ext : fwd_ext) + (NEG_STRAFE[k] ? -str_ext : str_ext);
      spd_d[k] = {lin[k][33], lin[k][33:15]} + {{3{rot[16]}}, rot};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      spd_q   <= spd_d;
      stop2_q <= stop1_q;
    end
  end

  // Stage three: output scaling.
  logic signed [36:0] scl_d [NumWheels];
  logic signed [36:0] scl_q [NumWheels];
  logic               stop3_q;

  always_comb begin
    for (int unsigned k = 0; k < NumWheels; k++) begin
      scl_d[k] = 37'(spd_q[k]) * 37'($signed({1'b0, cfg.output_scale}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready) begin
      scl_q   <= scl_d;
      stop3_q <= stop2_q;
    end
  end

  // Stage four: truncate toward zero, clamp and apply the stop.
  logic signed [36:0] adj  [NumWheels];
  logic signed [20:0] quo  [NumWheels];
  logic signed [8:0]  pwm_d [NumWheels];
  logic signed [8:0]  pwm_q [NumWheels];
  logic               stop4_q;

  always_comb begin
    for (int unsigned k = 0; k < NumWheels; k++) begin
      adj[k] = scl_q[k] + $signed(scl_q[k][36] ? TRUNC_BIAS : 37'd0);
      quo[k] = adj[k][36:16];
      if (stop3_q) begin
        pwm_d[k] = 9'sd0;
      end else if (quo[k] > 21'(WHEEL_MAX)) begin
        pwm_d[k] = WHEEL_MAX;
      end else if (quo[k] < 21'(WHEEL_MIN)) begin
        pwm_d[k] = WHEEL_MIN;
      end else begin
        pwm_d[k] = quo[k][8:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready) begin
      pwm_q   <= pwm_d;
      stop4_q <= stop3_q;
    end
  end

  assign out_valid_o     = s4_valid_q;
  assign wheel_front_a_o = pwm_q[0];
  assign wheel_front_b_o = pwm_q[1];
  assign wheel_rear_a_o  = pwm_q[2];
  assign wheel_rear_b_o  = pwm_q[3];
  assign stopped_o       = stop4_q;

endmodule

// ===== rtl/core/fwvm_checker.sv =====
// Port level checker of the velocity mixer and its bind to the top level.
// Depends on four_wheel_velocity_mixer_unit_assert.svh for the macros.
`timescale 1ns / 1ps
`include "four_wheel_velocity_mixer_unit_assert.svh"

module fwvm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [8:0] wheel_front_a_i,
  input logic [8:0] wheel_front_b_i,
  input logic [8:0] wheel_rear_a_i,
  input logic [8:0] wheel_rear_b_i,
  input logic       stopped_i
);

  logic [35:0] wheels;
  logic        in_range;
  logic        held;

  assign wheels = {wheel_front_a_i, wheel_front_b_i, wheel_rear_a_i, wheel_rear_b_i};
  assign in_range = (wheel_front_a_i != 9'h100) && (wheel_front_b_i != 9'h100)
                 && (wheel_rear_a_i != 9'h100) && (wheel_rear_b_i != 9'h100);
  assign held = out_valid_i && !out_ready_i;

  `FWVM_ASSERT_SAME(a_stop_zero, clk_i, rst_ni, out_valid_i && stopped_i, wheels == 36'd0)
  `FWVM_ASSERT_SAME(a_clamp_range, clk_i, rst_ni, out_valid_i, in_range)
  `FWVM_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, held, out_valid_i)
  `FWVM_ASSERT_NEXT(a_data_hold, clk_i, rst_ni, held, $stable(wheels) && $stable(stopped_i))

endmodule

bind four_wheel_velocity_mixer_unit fwvm_checker u_fwvm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .wheel_front_a_i (wheel_front_a_o),
  .wheel_front_b_i (wheel_front_b_o),
  .wheel_rear_a_i  (wheel_rear_a_o),
  .wheel_rear_b_i  (wheel_rear_b_o),
  .stopped_i       (stopped_o)
);

// ===== dv/tb_four_wheel_velocity_mixer_unit.sv =====
// Self-checking testbench for four_wheel_velocity_mixer_unit: directed and random commands
// under several register settings, checked against an in-bench wheel mix predictor.
// Depends on fwvm_pkg and the four_wheel_velocity_mixer_unit RTL.
`timescale 1ns / 1ps

module tb_four_wheel_velocity_mixer_unit;
  import fwvm_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 8;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PROBES      = 24;
  localparam int NUM_CFG_SLOTS   = 8;
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_AFTER      = 300;
  localparam int MAX_REPORTS     = 10;
  localparam int WHEEL_CAP       = 255;
  localparam logic [2:0] CFG_IDX_SPARE = 3'd7;

  typedef struct packed {
    logic signed [8:0] front_a;
    logic signed [8:0] front_b;
    logic signed [8:0] rear_a;
    logic signed [8:0] rear_b;
    logic              stopped;
  } wheel_set_t;

  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] str;
    logic signed [15:0] trn;
    logic               known;
    wheel_set_t         want;
  } probe_row_t;

  localparam wheel_set_t ANY_SET      = '0;
  localparam wheel_set_t STOP_SET     = '{9'sd0, 9'sd0, 9'sd0, 9'sd0, 1'b1};
  localparam wheel_set_t FWD_FULL     = '{-9'sd255, 9'sd255, -9'sd255, 9'sd255, 1'b0};
  localparam wheel_set_t FWD_FULL_REV = '{9'sd255, -9'sd255, 9'sd255, -9'sd255, 1'b0};
  localparam wheel_set_t STR_FULL     = '{9'sd255, 9'sd255, -9'sd255, -9'sd255, 1'b0};
  localparam wheel_set_t STR_FULL_REV = '{-9'sd255, -9'sd255, 9'sd255, 9'sd255, 1'b0};

  localparam int FWD_SIGN [4] = '{-1, 1, -1, 1};
  localparam int STR_SIGN [4] = '{1, 1, -1, -1};
  localparam logic signed [15:0] EDGE_VALS [6] =
    '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};

  probe_row_t probes [NUM_PROBES] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, STOP_SET},
    '{16'sd32767, 16'sd0, 16'sd0, 1'b1, FWD_FULL},
    '{16'sh8000, 16'sd0, 16'sd0, 1'b1, FWD_FULL_REV},
    '{16'sd0, 16'sd32767, 16'sd0, 1'b1, STR_FULL},
    '{16'sd0, 16'sh8000, 16'sd0, 1'b1, STR_FULL_REV},
    '{16'sd0, 16'sd0, 16'sd32767, 1'b0, ANY_SET},
    '{16'sd0, 16'sd0, 16'sh8000, 1'b0, ANY_SET},
    '{16'sd40, 16'sd0, 16'sd0, 1'b1, STOP_SET},
    '{16'sd41, 16'sd0, 16'sd0, 1'b0, ANY_SET},
    '{-16'sd40, 16'sd0, 16'sd0, 1'b1, STOP_SET},
    '{-16'sd41, 16'sd0, 16'sd0, 1'b0, ANY_SET},
    '{16'sd0, 16'sd40, 16'sd0, 1'b1, STOP_SET},
    '{16'sd0, 16'sd41, 16'sd0, 1'b0, ANY_SET},
    '{16'sd0, -16'sd41, 16'sd0, 1'b0, ANY_SET},
    '{16'sd0, 16'sd0, 16'sd63, 1'b1, STOP_SET},
    '{16'sd0, 16'sd0, -16'sd63, 1'b1, STOP_SET},
    '{16'sd0, 16'sd0, 16'sd64, 1'b0, ANY_SET},
    '{16'sd0, 16'sd0, -16'sd64, 1'b0, ANY_SET},
    '{16'sd40, -16'sd40, -16'sd63, 1'b1, STOP_SET},
    '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, ANY_SET},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, ANY_SET},
    '{-16'sd1, -16'sd1, -16'sd1, 1'b1, STOP_SET},
    '{16'sd32767, 16'sh8000, 16'sd0, 1'b0, ANY_SET},
    '{16'sd1000, -16'sd500, 16'sd300, 1'b0, ANY_SET}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic signed [15:0] forward_vel_i = '0;
  logic signed [15:0] strafe_vel_i = '0;
  logic signed [15:0] turn_rate_i = '0;
  logic out_ready_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_ready_o;
  logic out_valid_o;
  logic signed [8:0] wheel_front_a_o;
  logic signed [8:0] wheel_front_b_o;
  logic signed [8:0] wheel_rear_a_o;
  logic signed [8:0] wheel_rear_b_o;
  logic stopped_o;
  logic cfg_ready_o;

  // Register mirror, reset values as documented for the block.
  logic [15:0] k_fwd = 16'd26218;
  logic [15:0] k_str = 16'd15905;
  logic [15:0] k_turn = 16'd6420;
  logic [15:0] k_scale = 16'd2511;
  logic [14:0] db_fwd = 15'd41;
  logic [14:0] db_str = 15'd41;
  logic [14:0] db_turn = 15'd64;

  wheel_set_t pending_wheels [$];
  int fault_count = 0;
  int items_taken = 0;
  int cycle_count = 0;
  int burst_left = 0;

  four_wheel_velocity_mixer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .forward_vel_i  (forward_vel_i),
    .strafe_vel_i   (strafe_vel_i),
    .turn_rate_i    (turn_rate_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .wheel_front_a_o(wheel_front_a_o),
    .wheel_front_b_o(wheel_front_b_o),
    .wheel_rear_a_o (wheel_rear_a_o),
    .wheel_rear_b_o (wheel_rear_b_o),
    .stopped_o      (stopped_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("four_wheel_velocity_mixer_unit regression: fail");
      $finish;
    end
  end

  function automatic longint magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic wheel_set_t mix_wheels(input logic signed [15:0] fwd,
                                            input logic signed [15:0] str,
                                            input logic signed [15:0] trn);
    longint v, s, w, cf, cs, ct, sc, rot, spd, pwm;
    logic signed [8:0] duty [4];
    wheel_set_t r;
    v = fwd;
    s = str;
    w = trn;
    cf = k_fwd;
    cs = k_str;
    ct = k_turn;
    sc = k_scale;
    if (magnitude(v) < db_fwd && magnitude(s) < db_str && magnitude(w) < db_turn) begin
      return STOP_SET;
    end
    rot = (ct * w) >>> 16;
    for (int k = 0; k < 4; k++) begin
      spd = ((FWD_SIGN[k] * cf * v + STR_SIGN[k] * cs * s) >>> 15) + rot;
      pwm = (spd * sc) / 65536;
      if (pwm > WHEEL_CAP) pwm = WHEEL_CAP;
      if (pwm < -WHEEL_CAP) pwm = -WHEEL_CAP;
      duty[k] = pwm[8:0];
    end
    r.front_a = duty[0];
    r.front_b = duty[1];
    r.rear_a  = duty[2];
    r.rear_b  = duty[3];
    r.stopped = 1'b0;
    return r;
  endfunction

  function automatic logic signed [15:0] near_band(input logic [14:0] db);
    int x;
    x = int'($urandom_range(0, 2 * db + 4)) - int'(db) - 2;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return 16'(x);
  endfunction

  task automatic draw_command(output logic signed [15:0] f, output logic signed [15:0] s,
                              output logic signed [15:0] t);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      f = 16'($urandom);
      s = 16'($urandom);
      t = 16'($urandom);
    end else if (pick < 60) begin
      f = 16'(int'($urandom_range(0, 16000)) - 8000);
      s = 16'(int'($urandom_range(0, 16000)) - 8000);
      t = 16'(int'($urandom_range(0, 16000)) - 8000);
    end else if (pick < 85) begin
      f = near_band(db_fwd);
      s = near_band(db_str);
      t = near_band(db_turn);
    end else begin
      f = EDGE_VALS[$urandom_range(0, 5)];
      s = EDGE_VALS[$urandom_range(0, 5)];
      t = EDGE_VALS[$urandom_range(0, 5)];
    end
  endtask

  // Called on a rising edge; returns on the rising edge at which the item is taken.
  task automatic offer(input logic signed [15:0] f, input logic signed [15:0] s,
                       input logic signed [15:0] t, input logic known,
                       input wheel_set_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    forward_vel_i <= f;
    strafe_vel_i  <= s;
    turn_rate_i   <= t;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    pending_wheels.push_back(known ? want : mix_wheels(f, s, t));
    items_taken++;
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] bank [NUM_CFG_SLOTS]);
    for (int i = 0; i < NUM_CFG_SLOTS; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i  <= bank[i];
      @(negedge clk_i);
      while (!cfg_ready_o) @(negedge clk_i);
      case (cfg_reg_e'(i))
        REG_COEF_FORWARD:     k_fwd = bank[i];
        REG_COEF_STRAFE:      k_str = bank[i];
        REG_COEF_TURN:        k_turn = bank[i];
        REG_OUTPUT_SCALE:     k_scale = bank[i];
        REG_FORWARD_DEADBAND: db_fwd = bank[i][14:0];
        REG_STRAFE_DEADBAND:  db_str = bank[i][14:0];
        REG_TURN_DEADBAND:    db_turn = bank[i][14:0];
        default: ;
      endcase
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // The receiver runs its own pattern and once holds off long enough to back up the pipe.
  initial begin : receiver
    bit held;
    int run;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && items_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if ($urandom_range(0, 9) < 3) begin
        out_ready_i <= 1'b0;
        run = $urandom_range(1, 6);
      end else begin
        out_ready_i <= 1'b1;
        run = $urandom_range(1, 30);
      end
      repeat (run) @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin
    wheel_set_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{wheel_front_a_o, wheel_front_b_o, wheel_rear_a_o, wheel_rear_b_o, stopped_o};
      if (pending_wheels.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected item: %0d %0d %0d %0d stop %0b", got.front_a, got.front_b,
                   got.rear_a, got.rear_b, got.stopped);
      end else begin
        want = pending_wheels.pop_front();
        if (got.front_a !== want.front_a || got.front_b !== want.front_b ||
            got.rear_a !== want.rear_a || got.rear_b !== want.rear_b ||
            got.stopped !== want.stopped) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("mismatch: expected %0d %0d %0d %0d stop %0b, got %0d %0d %0d %0d stop %0b",
                     want.front_a, want.front_b, want.rear_a, want.rear_b, want.stopped,
                     got.front_a, got.front_b, got.rear_a, got.rear_b, got.stopped);
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] bank [NUM_CFG_SLOTS];
    logic signed [15:0] f, s, t;
    wait (rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < NUM_PROBES; i++) begin
      offer(probes[i].fwd, probes[i].str, probes[i].trn, probes[i].known, probes[i].want);
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: bank = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
          2: bank = '{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0};
          3: begin
            bank[0] = 16'($urandom_range(0, 32768));
            bank[1] = 16'($urandom_range(0, 32768));
            bank[2] = 16'($urandom_range(0, 65535));
            bank[3] = 16'($urandom_range(1000, 65535));
            bank[4] = 16'($urandom_range(0, 2000));
            bank[5] = 16'($urandom_range(0, 2000));
            bank[6] = 16'($urandom_range(0, 2000));
          end
          4: begin
            for (int i = 0; i < NUM_CFG_SLOTS; i++) bank[i] = 16'($urandom);
          end
          5: bank = '{16'd32768, 16'd32768, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0};
          default: bank = '{16'd26218, 16'd15905, 16'd6420, 16'd2511,
                            16'd41, 16'd41, 16'd64, 16'd0};
        endcase
        bank[CFG_IDX_SPARE] = 16'($urandom);
        configure(bank);
      end
      repeat (ITEMS_PER_PHASE) begin
        draw_command(f, s, t);
        offer(f, s, t, 1'b0, ANY_SET);
      end
    end
    settle();
    if (fault_count == 0 && pending_wheels.size() == 0) begin
      $display("four_wheel_velocity_mixer_unit regression: pass");
    end else begin
      $display("four_wheel_velocity_mixer_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/fwvm_pkg.sv
rtl/core/fwvm_cfg_regs.sv
rtl/core/four_wheel_velocity_mixer_unit.sv
rtl/core/fwvm_checker.sv
dv/tb_four_wheel_velocity_mixer_unit.sv
